[design/dbtg_pkg.sv]
package dbtg_pkg;

  // offset arithmetic width
  localparam int unsigned OFFSET_BITS = 20;
  // row/cell index width that still reaches every offset bit after the x32 scale
  localparam int unsigned IDX_W = OFFSET_BITS - 5;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ACTION_W = 2;

  // language modes
  localparam logic [MODE_W-1:0] MODE_ASCII = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJIS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EUC   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd3;

  // glyph actions
  localparam logic [ACTION_W-1:0] ACT_HOLD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_HALF = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FULL = 2'd2;

  // byte ranges
  localparam logic [7:0] SJIS_LEAD1_LO = 8'h81;
  localparam logic [7:0] SJIS_LEAD1_HI = 8'h9f;
  localparam logic [7:0] SJIS_LEAD2_LO = 8'he0;
  localparam logic [7:0] SJIS_LEAD2_HI = 8'hfc;
  localparam logic [7:0] SJIS_TRL1_LO  = 8'h40;
  localparam logic [7:0] SJIS_TRL1_HI  = 8'h7e;
  localparam logic [7:0] SJIS_TRL2_LO  = 8'h80;
  localparam logic [7:0] SJIS_TRL2_HI  = 8'h9e;
  localparam logic [7:0] SJIS_TRL3_BASE = 8'h9f;
  localparam logic [7:0] EUC_LEAD_LO   = 8'h81;
  localparam logic [7:0] EUC_LEAD_HI   = 8'hfe;
  localparam logic [7:0] EUC_BASE      = 8'ha1;

  localparam int unsigned ROW_CELLS     = 94;
  localparam int unsigned SJIS_ROW_SKIP = 62;
  localparam int unsigned SJIS_CELL_SKIP = 63;
  localparam int unsigned JP_FULL_BASE  = 4096;

  // one glyph command word
  typedef struct packed {
    logic [ACTION_W-1:0]    action;
    logic                   font_bank;
    logic [OFFSET_BITS-1:0] glyph_offset;
  } glyph_cmd_t;

endpackage

[design/dbtg_decode.sv]
module dbtg_decode (
  input  logic [dbtg_pkg::MODE_W-1:0] mode_i,
  input  logic [7:0]                  byte_i,
  input  logic [7:0]                  held_i,
  output logic                        emit_o,
  output logic [7:0]                  held_o,
  output dbtg_pkg::glyph_cmd_t        cmd_o
);
  import dbtg_pkg::*;

  logic             is_lead;
  logic [IDX_W-1:0] lead_x;
  logic [IDX_W-1:0] byte_x;
  logic [IDX_W-1:0] row_k;
  logic [IDX_W-1:0] cell_t;
  logic [IDX_W-1:0] glyph_idx;
  logic [OFFSET_BITS-1:0] half_offset;
  logic [OFFSET_BITS-1:0] full_offset;

  assign lead_x = IDX_W'(held_i);
  assign byte_x = IDX_W'(byte_i);

  // lead byte detection per mode
  always_comb begin
    if (mode_i == MODE_SJIS) begin
      is_lead = (byte_i >= SJIS_LEAD1_LO && byte_i <= SJIS_LEAD1_HI) ||
                (byte_i >= SJIS_LEAD2_LO && byte_i <= SJIS_LEAD2_HI);
    end else begin
      is_lead = (byte_i >= EUC_LEAD_LO && byte_i <= EUC_LEAD_HI);
    end
  end

  // jis row and cell from the held lead byte and this trail byte, wrapped
  always_comb begin
    if (mode_i == MODE_SJIS) begin
      if (held_i >= SJIS_LEAD1_LO && held_i <= SJIS_LEAD1_HI) begin
        row_k = (lead_x - IDX_W'(SJIS_LEAD1_LO)) << 1;
      end else begin
        row_k = ((lead_x - IDX_W'(SJIS_LEAD2_LO)) << 1) + IDX_W'(SJIS_ROW_SKIP);
      end
      if (byte_i >= SJIS_TRL1_LO && byte_i <= SJIS_TRL1_HI) begin
        cell_t = byte_x - IDX_W'(SJIS_TRL1_LO);
      end else if (byte_i >= SJIS_TRL2_LO && byte_i <= SJIS_TRL2_HI) begin
        cell_t = byte_x - IDX_W'(SJIS_TRL2_LO) + IDX_W'(SJIS_CELL_SKIP);
      end else begin
        // upper trail range sits in the odd row
        cell_t = byte_x - IDX_W'(SJIS_TRL3_BASE);
        row_k  = row_k + IDX_W'(1);
      end
    end else begin
      row_k  = lead_x - IDX_W'(EUC_BASE);
      cell_t = byte_x - IDX_W'(EUC_BASE);
    end
  end

  // glyph index and byte offsets
  assign glyph_idx   = IDX_W'(row_k * IDX_W'(ROW_CELLS)) + cell_t;
  assign full_offset = {glyph_idx, 5'b0} + OFFSET_BITS'(JP_FULL_BASE);
  assign half_offset = OFFSET_BITS'({byte_i, 4'b0});

  // command selection
  always_comb begin
    emit_o = 1'b1;
    held_o = held_i;
    cmd_o  = '0;
    unique case (mode_i) inside
      MODE_ASCII: begin
        cmd_o.action       = ACT_HALF;
        cmd_o.glyph_offset = half_offset;
      end
      MODE_SJIS, MODE_EUC: begin
        if (held_i == 8'h00) begin
          if (is_lead) begin
            held_o       = byte_i;
            cmd_o.action = ACT_HOLD;
          end else begin
            cmd_o.action       = ACT_HALF;
            cmd_o.font_bank    = 1'b1;
            cmd_o.glyph_offset = half_offset;
          end
        end else begin
          held_o             = 8'h00;
          cmd_o.action       = ACT_FULL;
          cmd_o.font_bank    = 1'b1;
          cmd_o.glyph_offset = full_offset;
        end
      end
      default: begin
        // mode three drops the byte
        emit_o = 1'b0;
      end
    endcase
  end

endmodule

[design/double_byte_text_glyph_decoder.sv]
// double-byte text glyph decoder
// input channel: one text byte per word on code_byte_i, in_valid_i / in_ready_o.
// output channel: one glyph command per word (action_o, font_bank_o,
//   glyph_offset_o), out_valid_o / out_ready_i.
// config channel: cfg_valid_i / cfg_ready_o with lang_mode_i; always ready, write
//   it only while no byte is in flight.
// path: a byte accepted sits in the input register, and its command is
//   decoded combinationally into the result register, which drives out_valid_o.
//   throughput: one byte per cycle while the receiver does not stall.
// in mode 1 or 2 a lead byte gives a hold command (action 0) and is kept
//   until the next byte in mode 1 or 2 forms the full-width glyph.
// in mode 3 a byte is accepted and dropped with no command.
// reset clears the mode to single-byte ascii, drops any held lead byte and
//   empties both registers.
// when the receiver stalls the result register holds its word; the input
//   register still takes one more byte, after which in_ready_o drops until
//   the result is taken.
module double_byte_text_glyph_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       lang_mode_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       code_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       action_o,
  output logic                             font_bank_o,
  output logic [dbtg_pkg::OFFSET_BITS-1:0] glyph_offset_o
);
  import dbtg_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic [7:0]        held_q;
  logic              out_valid_q;
  glyph_cmd_t        cmd_q;

  logic              out_free;
  logic              advance;
  logic              emit;
  logic [7:0]        held_d;
  glyph_cmd_t        cmd_d;

  assign cfg_ready_o = 1'b1;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ASCII;
    end else if (cfg_valid_i) begin
      mode_q <= lang_mode_i;
    end
  end

  // pipeline control
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= code_byte_i;
    end
  end

  dbtg_decode u_decode (
    .mode_i (mode_q),
    .byte_i (byte_q),
    .held_i (held_q),
    .emit_o (emit),
    .held_o (held_d),
    .cmd_o  (cmd_d)
  );

  // held lead byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 8'h00;
    end else if (advance) begin
      held_q <= held_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = cmd_q.action;
  assign font_bank_o    = cmd_q.font_bank;
  assign glyph_offset_o = cmd_q.glyph_offset;

endmodule

[design/dbtg_checker.sv]
module dbtg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [1:0]                       action_o,
  input logic                             font_bank_o,
  input logic [dbtg_pkg::OFFSET_BITS-1:0] glyph_offset_o
);
  import dbtg_pkg::*;

  // a stalled word is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a hold command carries no glyph
  a_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_HOLD |-> !font_bank_o && glyph_offset_o == '0)
    else $error("hold command with glyph fields set");

  // full-width glyphs come from the japanese font on 32-byte bounds
  a_full_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_FULL |-> font_bank_o && glyph_offset_o[4:0] == 5'd0)
    else $error("bad full-width glyph command");

  // a fresh word follows a byte taken by the input handshake
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output word without an input byte");

endmodule

bind double_byte_text_glyph_decoder dbtg_checker u_dbtg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .action_o       (action_o),
  .font_bank_o    (font_bank_o),
  .glyph_offset_o (glyph_offset_o)
);
